@@ hdl/euler_zyx_pose_to_transform_macros.svh @@
// Assertion macros shared by the pose-to-transform RTL files.
`ifndef EULER_ZYX_POSE_TO_TRANSFORM_MACROS_SVH
`define EULER_ZYX_POSE_TO_TRANSFORM_MACROS_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define EZ_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Asserts that an antecedent implies a consequent in the next cycle.
`define EZ_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ hdl/ezp_pkg.sv @@
// Package with item types and constants of the pose-to-transform block.
`default_nettype none
package ezp_pkg;
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } t_pose;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } t_xform;

    // One angle lane of the data handed from one CORDIC cell to the next.
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [31:0] z;
        logic               neg;
    } t_lane;

    typedef struct packed {
        logic         vld;
        t_lane [2:0]  lane;
        logic [95:0]  pos;
    } t_cell;

    localparam int ATAN_COUNT = 24;
    localparam logic signed [31:0] ANG_PI = 32'sd843314857;
    localparam logic signed [32:0] ANG_2PI = 33'sd1686629713;
    localparam logic signed [31:0] ANG_HALFPI = 32'sd421657428;
    localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
        case (i)
            5'd0: atan_q28 = 32'sd210828714;
            5'd1: atan_q28 = 32'sd124459457;
            5'd2: atan_q28 = 32'sd65760959;
            5'd3: atan_q28 = 32'sd33381290;
            5'd4: atan_q28 = 32'sd16755422;
            5'd5: atan_q28 = 32'sd8385879;
            5'd6: atan_q28 = 32'sd4193963;
            5'd7: atan_q28 = 32'sd2097109;
            5'd8: atan_q28 = 32'sd1048571;
            5'd9: atan_q28 = 32'sd524287;
            default: atan_q28 = 32'sd1 <<< (5'd28 - i);
        endcase
    endfunction
endpackage
`default_nettype wire

@@ hdl/euler_zyx_pose_to_transform.sv @@
// Top level: angle reduction, chain of CORDIC cells and matrix back end.
// The chain holds CORDIC_STAGES cells, capped at ATAN_COUNT.
// Throughput: one pose per cycle; busy is always low.
// Reset: synchronous active-low i_rst_n clears all valid flags.
// The receiver cannot stall; each result shows for one cycle with o_done.
`default_nettype none
module euler_zyx_pose_to_transform
    import ezp_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   start,
    output logic        busy,
    input  wire t_pose  i_pose,
    output logic        o_done,
    output t_xform      o_xform
);
    `include "euler_zyx_pose_to_transform_macros.svh"

    localparam int NumCells = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

    function automatic t_lane reduce(input logic signed [15:0] a);
        t_lane l;
        logic signed [32:0] z;
        z = 33'(a) <<< 16;
        if (z > 33'(ANG_PI)) z = z - ANG_2PI;
        else if (z <= -33'(ANG_PI)) z = z + ANG_2PI;
        if (z > 33'(ANG_HALFPI)) z = z - 33'(ANG_PI);
        if (z < -33'(ANG_HALFPI)) z = z + 33'(ANG_PI);
        l.neg = (33'(a) <<< 16) != z && !((33'(a) <<< 16) - z == ANG_2PI
            || z - (33'(a) <<< 16) == ANG_2PI);
        l.x = GAIN_Q30;
        l.y = 33'sd0;
        l.z = z[31:0];
        return l;
    endfunction

    t_cell r_in;
    t_cell w_chain [NumCells+1];

    always_ff @(posedge i_clk) begin
        r_in.vld <= start && !busy;
        r_in.lane[0] <= reduce(i_pose.angle_x);
        r_in.lane[1] <= reduce(i_pose.angle_y);
        r_in.lane[2] <= reduce(i_pose.angle_z);
        r_in.pos <= {i_pose.pos_x, i_pose.pos_y, i_pose.pos_z};
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end
    end

    assign busy = 1'b0;
    assign w_chain[0] = r_in;

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        ezp_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell (w_chain[g]),
            .o_cell (w_chain[g+1])
        );
    end

    ezp_matrix u_matrix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cell (w_chain[NumCells]),
        .o_vld  (o_done),
        .o_xform(o_xform)
    );

    `EZ_ASSERT_NEXT(a_accept, i_clk, i_rst_n, start, r_in.vld)
    `EZ_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `EZ_ASSERT_IMPL(a_lane_gain, i_clk, i_rst_n, r_in.vld, r_in.lane[0].x == GAIN_Q30)
endmodule
`default_nettype wire

@@ hdl/ezp_cell.sv @@
// One CORDIC rotation cell for three angle lanes, registered.
`default_nettype none
module ezp_cell
    import ezp_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cell i_cell,
    output t_cell      o_cell
);
    localparam logic [4:0] Idx = 5'(STAGE);
    t_cell r_cell;
    t_cell n_cell;

    always_comb begin
        n_cell = i_cell;
        for (int k = 0; k < 3; k++) begin
            if (!i_cell.lane[k].z[31]) begin
                n_cell.lane[k].x = i_cell.lane[k].x - (i_cell.lane[k].y >>> Idx);
                n_cell.lane[k].y = i_cell.lane[k].y + (i_cell.lane[k].x >>> Idx);
                n_cell.lane[k].z = i_cell.lane[k].z - atan_q28(Idx);
            end else begin
                n_cell.lane[k].x = i_cell.lane[k].x + (i_cell.lane[k].y >>> Idx);
                n_cell.lane[k].y = i_cell.lane[k].y - (i_cell.lane[k].x >>> Idx);
                n_cell.lane[k].z = i_cell.lane[k].z + atan_q28(Idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

@@ hdl/ezp_matrix.sv @@
// Rotation matrix back end: clamp, products in registered steps, rounding.
`default_nettype none
module ezp_matrix
    import ezp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cell i_cell,
    output logic       o_vld,
    output t_xform     o_xform
);
    `include "euler_zyx_pose_to_transform_macros.svh"

    function automatic logic signed [31:0] clamp(input logic signed [32:0] v,
                                                 input logic neg);
        logic signed [33:0] w;
        w = neg ? -34'(v) : 34'(v);
        if (w > 34'(ONE_Q30)) clamp = ONE_Q30;
        else if (w < -34'(ONE_Q30)) clamp = -ONE_Q30;
        else clamp = w[31:0];
    endfunction

    function automatic logic signed [15:0] ent(input logic signed [63:0] q);
        logic signed [63:0] v;
        v = (q + (64'sd1 <<< 45)) >>> 46;
        if (v > 64'sd16384) ent = 16'sd16384;
        else if (v < -64'sd16384) ent = -16'sd16384;
        else ent = v[15:0];
    endfunction

    function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] v;
        v = (p + (64'sd1 <<< 29)) >>> 30;
        rnd30 = v[31:0];
    endfunction

    // Step 1: clamped sine and cosine.
    logic               r_v1;
    logic signed [31:0] r_cx, r_sx, r_cy, r_sy, r_cz, r_sz;
    logic [95:0]        r_p1;
    // Step 2: pair products.
    logic               r_v2;
    logic signed [63:0] r_czcy, r_szcy, r_szcx, r_szsx, r_czcx, r_czsx;
    logic signed [63:0] r_cysx, r_cycx, r_nsy, r_czsy, r_szsy;
    logic signed [31:0] r_cx2, r_sx2;
    logic [95:0]        r_p2;
    // Step 3: triple products.
    logic               r_v3;
    logic signed [63:0] r_t01, r_t02, r_t11, r_t12;
    logic signed [63:0] r_czcy3, r_szcy3, r_szcx3, r_szsx3, r_czcx3, r_czsx3;
    logic signed [63:0] r_cysx3, r_cycx3, r_nsy3;
    logic [95:0]        r_p3;
    // Step 4: output register.
    logic               r_v4;
    t_xform             r_out;
    logic signed [31:0] w_czsy, w_szsy;

    assign w_czsy = rnd30(r_czsy);
    assign w_szsy = rnd30(r_szsy);

    always_ff @(posedge i_clk) begin
        r_v1 <= i_cell.vld;
        r_cx <= clamp(i_cell.lane[0].x, i_cell.lane[0].neg);
        r_sx <= clamp(i_cell.lane[0].y, i_cell.lane[0].neg);
        r_cy <= clamp(i_cell.lane[1].x, i_cell.lane[1].neg);
        r_sy <= clamp(i_cell.lane[1].y, i_cell.lane[1].neg);
        r_cz <= clamp(i_cell.lane[2].x, i_cell.lane[2].neg);
        r_sz <= clamp(i_cell.lane[2].y, i_cell.lane[2].neg);
        r_p1 <= i_cell.pos;

        r_v2   <= r_v1;
        r_czcy <= 64'(r_cz) * 64'(r_cy);
        r_szcy <= 64'(r_sz) * 64'(r_cy);
        r_szcx <= 64'(r_sz) * 64'(r_cx);
        r_szsx <= 64'(r_sz) * 64'(r_sx);
        r_czcx <= 64'(r_cz) * 64'(r_cx);
        r_czsx <= 64'(r_cz) * 64'(r_sx);
        r_cysx <= 64'(r_cy) * 64'(r_sx);
        r_cycx <= 64'(r_cy) * 64'(r_cx);
        r_nsy  <= -(64'(r_sy) <<< 30);
        r_czsy <= 64'(r_cz) * 64'(r_sy);
        r_szsy <= 64'(r_sz) * 64'(r_sy);
        r_cx2  <= r_cx;
        r_sx2  <= r_sx;
        r_p2   <= r_p1;

        r_v3    <= r_v2;
        r_t01   <= 64'(w_czsy) * 64'(r_sx2);
        r_t02   <= 64'(w_czsy) * 64'(r_cx2);
        r_t11   <= 64'(w_szsy) * 64'(r_sx2);
        r_t12   <= 64'(w_szsy) * 64'(r_cx2);
        r_czcy3 <= r_czcy;
        r_szcy3 <= r_szcy;
        r_szcx3 <= r_szcx;
        r_szsx3 <= r_szsx;
        r_czcx3 <= r_czcx;
        r_czsx3 <= r_czsx;
        r_cysx3 <= r_cysx;
        r_cycx3 <= r_cycx;
        r_nsy3  <= r_nsy;
        r_p3    <= r_p2;

        r_v4        <= r_v3;
        r_out.r00   <= ent(r_czcy3);
        r_out.r01   <= ent(r_t01 - r_szcx3);
        r_out.r02   <= ent(r_t02 + r_szsx3);
        r_out.r10   <= ent(r_szcy3);
        r_out.r11   <= ent(r_t11 + r_czcx3);
        r_out.r12   <= ent(r_t12 - r_czsx3);
        r_out.r20   <= ent(r_nsy3);
        r_out.r21   <= ent(r_cysx3);
        r_out.r22   <= ent(r_cycx3);
        r_out.out_x <= r_p3[95:64];
        r_out.out_y <= r_p3[63:32];
        r_out.out_z <= r_p3[31:0];
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end
    end

    assign o_vld = r_v4;
    assign o_xform = r_out;

    `EZ_ASSERT_NEXT(a_vld_flow, i_clk, i_rst_n, r_v3, r_v4)
    `EZ_ASSERT_NEXT(a_pos_flow, i_clk, i_rst_n, r_v3, r_out.out_x == $past(r_p3[95:64]))
    `EZ_ASSERT_IMPL(a_r20_range, i_clk, i_rst_n, r_v4,
        r_out.r20 <= 16'sd16384 && r_out.r20 >= -16'sd16384)
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the pose-to-transform block: directed and random poses against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import ezp_pkg::*;

    localparam int STAGES = 16;
    localparam longint PI_Q28 = 843314857;
    localparam longint TWO_PI_Q28 = 1686629713;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint GAIN = 652032874;
    localparam longint UNITY = 1073741824;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_pose  i_pose;
    logic   o_done;
    t_xform o_xform;

    t_xform pending_xforms[$];
    int     mismatches;
    bit     idling_on;

    euler_zyx_pose_to_transform #(
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_pose (i_pose),
        .o_done (o_done),
        .o_xform(o_xform)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint rot_table(int i);
        longint t[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                          8385879, 4193963, 2097109, 1048571, 524287};
        if (i < 10) begin
            return t[i];
        end
        return longint'(1) << (28 - i);
    endfunction

    task automatic cos_sin(input logic signed [15:0] ang, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = longint'(ang) * 65536;
        x = GAIN;
        y = 0;
        flip = 1'b0;
        while (z > PI_Q28) z -= TWO_PI_Q28;
        while (z <= -PI_Q28) z += TWO_PI_Q28;
        if (z > HALF_PI_Q28) begin
            z -= PI_Q28;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q28) begin
            z += PI_Q28;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= rot_table(i);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += rot_table(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        if (x > UNITY) x = UNITY;
        if (x < -UNITY) x = -UNITY;
        if (y > UNITY) y = UNITY;
        if (y < -UNITY) y = -UNITY;
        c = x;
        s = y;
    endtask

    function automatic logic signed [15:0] to_q14(longint q60);
        longint v;
        v = (q60 + (longint'(1) <<< 45)) >>> 46;
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    task automatic pose_to_xform(input t_pose p, output t_xform r);
        longint cx, sx, cy, sy, cz, sz, czsy, szsy;
        cos_sin(p.angle_x, cx, sx);
        cos_sin(p.angle_y, cy, sy);
        cos_sin(p.angle_z, cz, sz);
        czsy = (cz * sy + (longint'(1) <<< 29)) >>> 30;
        szsy = (sz * sy + (longint'(1) <<< 29)) >>> 30;
        r.r00 = to_q14(cz * cy);
        r.r01 = to_q14(czsy * sx - sz * cx);
        r.r02 = to_q14(czsy * cx + sz * sx);
        r.r10 = to_q14(sz * cy);
        r.r11 = to_q14(szsy * sx + cz * cx);
        r.r12 = to_q14(szsy * cx - cz * sx);
        r.r20 = to_q14(-sy * UNITY);
        r.r21 = to_q14(cy * sx);
        r.r22 = to_q14(cy * cx);
        r.out_x = p.pos_x;
        r.out_y = p.pos_y;
        r.out_z = p.pos_z;
    endtask

    // Start stays high after the item is taken; an idle burst lowers it.
    task automatic send_pose(input t_pose p);
        t_xform r;
        start <= 1'b1;
        i_pose <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pose_to_xform(p, r);
        pending_xforms = {pending_xforms, r};
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    function automatic t_pose make_pose(logic signed [15:0] ax, logic signed [15:0] ay,
                                        logic signed [15:0] az);
        t_pose p;
        p.pos_x = $urandom;
        p.pos_y = $urandom;
        p.pos_z = $urandom;
        p.angle_x = ax;
        p.angle_y = ay;
        p.angle_z = az;
        return p;
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 25736) - 12868);
            2: return 16'($urandom_range(0, 40) - 20 + ($urandom_range(0, 1) ? 6434 : -6434));
            default: return 16'($urandom_range(0, 40) - 20
                                + ($urandom_range(0, 1) ? 12868 : -12868));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_xforms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_xform);
            end else begin
                t_xform e;
                e = pending_xforms.pop_front();
                if (o_xform !== e) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %h", e);
                        $display("          actual   %h", o_xform);
                    end
                end
            end
        end
    end

    task automatic test_extreme_fields();
        t_pose p;
        p = make_pose(16'sh0000, 16'sh0000, 16'sh0000);
        p.pos_x = 32'h7fffffff;
        p.pos_y = 32'h80000000;
        p.pos_z = 32'hffffffff;
        send_pose(p);
        p = make_pose(16'sh7fff, 16'sh8000, 16'sh7fff);
        p.pos_x = 32'h80000000;
        p.pos_y = 32'h7fffffff;
        p.pos_z = 32'h00000000;
        send_pose(p);
        send_pose(make_pose(16'sh8000, 16'sh7fff, 16'sh8000));
        send_pose(make_pose(16'shffff, 16'sh0001, 16'shffff));
    endtask

    // Angles around plus and minus pi and pi/2 exercise the range reduction.
    task automatic test_reduction_edges();
        logic signed [15:0] edges[8] = '{16'sd12867, 16'sd12868, -16'sd12867, -16'sd12868,
                                          16'sd6433, 16'sd6434, -16'sd6433, -16'sd6434};
        for (int i = 0; i < 8; i++) begin
            send_pose(make_pose(edges[i], edges[7 - i], edges[(i + 3) % 8]));
        end
        send_pose(make_pose(16'sd25736, -16'sd25736, 16'sd19302));
        send_pose(make_pose(16'sd6434, 16'sd6434, 16'sd6434));
        send_pose(make_pose(-16'sd6434, 16'sd0, 16'sd12868));
    endtask

    task automatic test_random_poses(int count);
        for (int i = 0; i < count; i++) begin
            send_pose(make_pose(rand_angle(), rand_angle(), rand_angle()));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_pose = '0;
        mismatches = 0;
        idling_on = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_extreme_fields();
        test_reduction_edges();
        test_random_poses(500);
        idling_on = 1'b0;
        test_random_poses(130);
        start <= 1'b0;
        while (pending_xforms.size() != 0) @(negedge i_clk);
        repeat (STAGES + 20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("** euler_zyx_pose_to_transform: PASSED **");
        end else begin
            $display("** euler_zyx_pose_to_transform: FAILED **");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("** euler_zyx_pose_to_transform: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/ezp_pkg.sv
hdl/ezp_cell.sv
hdl/ezp_matrix.sv
hdl/euler_zyx_pose_to_transform.sv
tb/testbench.sv
